[rtl/bitmap_block_allocator_unit_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and muted while arst_n is low.
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and muted while arst_n is low.
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bba_pkg.sv]
// Constants and codes of the bitmap block allocator.
package bba_pkg;

	localparam int NUM_BLOCKS = 4096;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;

	localparam int BLK_W  = 12;
	localparam int CNT_W  = 13;
	localparam int ST_W   = 2;
	localparam int ADDR_W = $clog2(MAP_WORDS);
	localparam int BIT_W  = $clog2(WORD_BITS);

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
	localparam logic [ST_W-1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [ST_W-1:0] STAT_INVALID  = 2'd2;

	typedef logic [WORD_BITS-1:0] map_word_t;

endpackage

[rtl/bitmap_block_allocator_unit.sv]
// Bitmap free-block allocator: one bitmap RAM with read-modify-write control.
// A free passes through SCAN and DONE; a rejected free or an allocate that scans nothing
// goes straight to DONE; a scanning allocate reads one bitmap word per cycle from the hint's
// word on until it finds a free block or passes the last word, then enters DONE.
// One request is in flight at a time; the next is taken the cycle after its result
// enters the output register. Reset (arst_n low) empties the map.
module bitmap_block_allocator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request channel.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bba_pkg::IN_DATA_W-1:0]   s_tdata,  // [11:0] block_number, rest zero
	input  logic                            s_tuser,  // [0] req_type
	// Result channel.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bba_pkg::OUT_DATA_W-1:0]  m_tdata,  // [11:0] granted_block,
	                                                  // [13:12] status,
	                                                  // [26:14] free_blocks, rest zero
	// Configuration: data_start.
	input  logic                            cfg_we,
	input  logic [bba_pkg::BLK_W-1:0]       cfg_wdata
);
	import bba_pkg::*;

	`include "bitmap_block_allocator_unit_macros.svh"

	// IDLE takes a request, SCAN sees the word read in the cycle before,
	// DONE waits for room in the output register.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic              req_q;
	logic [BLK_W-1:0]  blk_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BLK_W-1:0]  res_blk_q;
	logic [ST_W-1:0]   res_st_q;
	logic [CNT_W-1:0]  free_count_q;
	logic [CNT_W-1:0]  hint_q;
	logic [BLK_W-1:0]  data_start_q;
	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// The bitmap. Each word carries a valid bit cleared by reset; a word never
	// written since reset reads as all zero, that is, no free block.
	map_word_t         map_mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] word_vld_q;
	map_word_t         rd_data_s1;
	logic              rd_vld_s1;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	map_word_t         wr_data;

	logic              s_accept;
	logic [BLK_W-1:0]  s_blk;
	map_word_t         word;
	logic [BIT_W-1:0]  low_idx;
	logic [BLK_W-1:0]  hit_blk;
	logic              hint_past_end;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign s_blk    = s_tdata[BLK_W-1:0];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign word          = rd_vld_s1 ? rd_data_s1 : '0;
	assign hint_past_end = (hint_q[CNT_W-1:BIT_W] >= (CNT_W-BIT_W)'(MAP_WORDS));
	assign hit_blk       = {addr_q, low_idx};

	// Lowest set bit of the word under inspection.
	always_comb begin
		low_idx = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (word[b]) begin
				low_idx = BIT_W'(b);
			end
		end
	end

	// Read port: a free reads the block's word, an allocate starts at the
	// hint's word and steps one word on for every empty word it sees.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q;
		if (state_q == ST_IDLE && s_accept) begin
			if (s_tuser == REQ_FREE) begin
				rd_en   = (s_blk >= data_start_q);
				rd_addr = s_blk[BLK_W-1:BIT_W];
			end else begin
				rd_en   = (free_count_q != '0) && !hint_past_end;
				rd_addr = hint_q[BIT_W+ADDR_W-1:BIT_W];
			end
		end else if (state_q == ST_SCAN && req_q == REQ_ALLOC && word == '0 &&
		             addr_q != ADDR_W'(MAP_WORDS - 1)) begin
			rd_en   = 1'b1;
			rd_addr = addr_q + ADDR_W'(1);
		end
	end

	// Write port: set the freed bit, or clear the granted one.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = word;
		if (state_q == ST_SCAN) begin
			if (req_q == REQ_FREE) begin
				wr_en   = 1'b1;
				wr_data = word | (map_word_t'(1) << blk_q[BIT_W-1:0]);
			end else if (word != '0) begin
				wr_en   = 1'b1;
				wr_data = word & ~(map_word_t'(1) << low_idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[addr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= map_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				word_vld_q[addr_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= word_vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= BLK_W'(1);
		end else if (cfg_we) begin
			data_start_q <= cfg_wdata;
		end
	end

	// Request sequencer, allocator state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			req_q        <= REQ_ALLOC;
			blk_q        <= '0;
			addr_q       <= '0;
			res_blk_q    <= '0;
			res_st_q     <= STAT_OK;
			free_count_q <= '0;
			hint_q       <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// DONE reloads the output register itself when it is taken.
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			if (rd_en) begin
				addr_q <= rd_addr;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						req_q     <= s_tuser;
						blk_q     <= s_blk;
						res_blk_q <= '0;
						if (rd_en) begin
							state_q <= ST_SCAN;
						end else begin
							// Rejected free, empty count or hint beyond the map.
							res_st_q <= (s_tuser == REQ_FREE) ? STAT_INVALID
							                                 : STAT_NO_SPACE;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (req_q == REQ_FREE) begin
						// A double free still counts; the count saturates.
						if (free_count_q < CNT_W'(NUM_BLOCKS)) begin
							free_count_q <= free_count_q + CNT_W'(1);
						end
						if ({1'b0, blk_q} < hint_q) begin
							hint_q <= {1'b0, blk_q};
						end
						res_st_q <= STAT_OK;
						state_q  <= ST_DONE;
					end else if (word != '0) begin
						free_count_q <= free_count_q - CNT_W'(1);
						hint_q       <= {1'b0, hit_blk} + CNT_W'(1);
						res_blk_q    <= hit_blk;
						res_st_q     <= STAT_OK;
						state_q      <= ST_DONE;
					end else if (!rd_en) begin
						// Reached the last word without a free block.
						res_st_q <= STAT_NO_SPACE;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {(OUT_DATA_W-CNT_W-ST_W-BLK_W)'(0),
						               free_count_q, res_st_q, res_blk_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BBA_ASSERT_IMP(a_count_bound, 1'b1, free_count_q <= CNT_W'(NUM_BLOCKS), "free count exceeds the block count")
	`BBA_ASSERT_IMP(a_no_rw_overlap, wr_en, !rd_en, "bitmap read and write in the same cycle")
	`BBA_ASSERT_NXT(a_read_then_scan, rd_en, state_q == ST_SCAN, "bitmap read data arrives outside the scan")
	`BBA_ASSERT_IMP(a_fail_no_grant, m_tvalid && m_tdata[13:12] != STAT_OK, m_tdata[11:0] == '0, "failed request reports a block")

endmodule
